// ----- src/s_record_stream_encoder_top_defines.svh -----
// Assertion macros shared by the encoder modules.
`ifndef S_RECORD_STREAM_ENCODER_TOP_DEFINES_SVH
`define S_RECORD_STREAM_ENCODER_TOP_DEFINES_SVH

`ifndef SYNTH
`define SRE_ASSERT(label, clk_s, rst_s, prop, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
        else $error(msg);
`define SRE_NEVER(label, clk_s, rst_s, cond, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) !(cond)) \
        else $error(msg);
`else
`define SRE_ASSERT(label, clk_s, rst_s, prop, msg)
`define SRE_NEVER(label, clk_s, rst_s, cond, msg)
`endif

`endif

// ----- src/sre_pkg.sv -----
package sre_pkg;

    localparam int MAX_DATA_BYTES_DEF = 16;

    typedef enum logic [1:0]
    {
        OP_HEADER = 2'd0,
        OP_DATA   = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_CLOSE  = 2'd3
    } op_t;

    typedef enum logic [1:0]
    {
        CFG_ADDR_WIDTH    = 2'd0,
        CFG_START_ADDRESS = 2'd1,
        CFG_HEADER_TEXT   = 2'd2,
        CFG_HEADER_LENGTH = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0]
    {
        REC_HEADER,
        REC_DATA,
        REC_COUNT,
        REC_TERM
    } rec_kind_t;

    // Controller states; each emitting state also names the record field being sent.
    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_S,
        ST_TYPE,
        ST_COUNT,
        ST_ADDR,
        ST_DATA,
        ST_CSUM,
        ST_NL
    } state_t;

    localparam logic [6:0] ASCII_S    = 7'h53;
    localparam logic [6:0] ASCII_ZERO = 7'h30;
    localparam logic [6:0] ASCII_A    = 7'h41;
    localparam logic [6:0] ASCII_NL   = 7'h0A;

    localparam logic [3:0] TYPE_HEADER = 4'd0;
    localparam logic [3:0] TYPE_DATA   = 4'd1;
    localparam logic [3:0] TYPE_COUNT  = 4'd5;
    localparam logic [3:0] TYPE_TERM   = 4'd9;

    typedef struct packed
    {
        logic      store;
        logic      load;
        rec_kind_t kind;
        logic      emit;
        state_t    phase;
        logic      nib;
        logic      last;
    } sre_cmd_t;

    typedef struct packed
    {
        logic       out_free;
        logic       fill_zero;
        logic       fill_last;
        logic [2:0] abytes;
    } sre_sts_t;

    function automatic logic [6:0] hex_char(input logic [3:0] n);
        logic [6:0] c;
        if (n < 4'd10)
        begin
            c = ASCII_ZERO + {3'b000, n};
        end
        else
        begin
            c = ASCII_A + {3'b000, n} - 7'd10;
        end
        return c;
    endfunction

endpackage

// ----- src/sre_controller.sv -----
`include "s_record_stream_encoder_top_defines.svh"

module sre_controller
    import sre_pkg::*;
#(
    parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF,
    localparam int SPAN  = (MAX_DATA_BYTES > 8) ? MAX_DATA_BYTES : 8,
    localparam int CNT_W = $clog2(SPAN),
    localparam int LEN_W = $clog2(SPAN + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  op_t              opcode,
    input  sre_sts_t         sts,
    input  logic [LEN_W-1:0] rec_len,
    output sre_cmd_t         cmd,
    output logic [CNT_W-1:0] idx,
    output logic [CNT_W-1:0] rd_idx
);

    state_t           state_reg, state_next;
    logic             nib_reg, nib_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             term_pending_reg, term_pending_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            nib_reg          <= 1'b0;
            idx_reg          <= '0;
            term_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            nib_reg          <= nib_next;
            idx_reg          <= idx_next;
            term_pending_reg <= term_pending_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        nib_next          = nib_reg;
        idx_next          = idx_reg;
        term_pending_next = term_pending_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (opcode)
                        OP_HEADER: state_next = ST_S;
                        OP_DATA:
                        begin
                            if (sts.fill_last)
                            begin
                                state_next = ST_S;
                            end
                        end
                        OP_FLUSH:
                        begin
                            if (!sts.fill_zero)
                            begin
                                state_next = ST_S;
                            end
                        end
                        OP_CLOSE:
                        begin
                            state_next        = ST_S;
                            term_pending_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_S:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_TYPE;
                end
            end
            ST_TYPE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_COUNT;
                    nib_next   = 1'b0;
                end
            end
            ST_COUNT:
            begin
                if (sts.out_free)
                begin
                    nib_next = !nib_reg;
                    if (nib_reg)
                    begin
                        state_next = ST_ADDR;
                        idx_next   = '0;
                    end
                end
            end
            ST_ADDR:
            begin
                if (sts.out_free)
                begin
                    nib_next = !nib_reg;
                    if (nib_reg)
                    begin
                        if (idx_reg == CNT_W'(sts.abytes - 3'd1))
                        begin
                            idx_next   = '0;
                            state_next = (rec_len == '0) ? ST_CSUM : ST_DATA;
                        end
                        else
                        begin
                            idx_next = idx_reg + CNT_W'(1);
                        end
                    end
                end
            end
            ST_DATA:
            begin
                if (sts.out_free)
                begin
                    nib_next = !nib_reg;
                    if (nib_reg)
                    begin
                        if (LEN_W'(idx_reg) + LEN_W'(1) == rec_len)
                        begin
                            state_next = ST_CSUM;
                        end
                        else
                        begin
                            idx_next = idx_reg + CNT_W'(1);
                        end
                    end
                end
            end
            ST_CSUM:
            begin
                if (sts.out_free)
                begin
                    nib_next = !nib_reg;
                    if (nib_reg)
                    begin
                        state_next = ST_NL;
                    end
                end
            end
            ST_NL:
            begin
                if (sts.out_free)
                begin
                    if (term_pending_reg)
                    begin
                        term_pending_next = 1'b0;
                        state_next        = ST_S;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.phase = state_reg;
        cmd.nib   = nib_reg;
        cmd.kind  = REC_HEADER;
        s_tready  = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.store  = s_tvalid && (opcode == OP_DATA);
                unique case (opcode)
                    OP_HEADER:
                    begin
                        cmd.load = s_tvalid;
                        cmd.kind = REC_HEADER;
                    end
                    OP_DATA:
                    begin
                        cmd.load = s_tvalid && sts.fill_last;
                        cmd.kind = REC_DATA;
                    end
                    OP_FLUSH:
                    begin
                        cmd.load = s_tvalid && !sts.fill_zero;
                        cmd.kind = REC_DATA;
                    end
                    OP_CLOSE:
                    begin
                        cmd.load = s_tvalid;
                        cmd.kind = REC_COUNT;
                    end
                endcase
            end
            ST_NL:
            begin
                // The count record's newline is followed by the terminator record.
                cmd.emit = sts.out_free;
                cmd.last = !term_pending_reg;
                cmd.load = sts.out_free && term_pending_reg;
                cmd.kind = REC_TERM;
            end
            default:
            begin
                cmd.emit = sts.out_free;
            end
        endcase
    end

    assign idx = idx_reg;

    // The buffer read is registered and addressed with the index the sequencer moves to.
    assign rd_idx = idx_next;

    `SRE_ASSERT(a_emit_needs_room, clk, rst_n, cmd.emit |-> sts.out_free, "emit while output full")
    `SRE_NEVER(a_pending_not_idle, clk, rst_n, term_pending_reg && state_reg == ST_IDLE, "terminator lost")
    `SRE_ASSERT(a_last_ends_item, clk, rst_n, (cmd.emit && cmd.last) |=> state_reg == ST_IDLE, "last not at end")

endmodule

// ----- src/sre_datapath.sv -----
`include "s_record_stream_encoder_top_defines.svh"

module sre_datapath
    import sre_pkg::*;
#(
    parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF,
    localparam int SPAN   = (MAX_DATA_BYTES > 8) ? MAX_DATA_BYTES : 8,
    localparam int CNT_W  = $clog2(SPAN),
    localparam int LEN_W  = $clog2(SPAN + 1),
    localparam int FILL_W = $clog2(MAX_DATA_BYTES + 1),
    localparam int IDX_W  = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       data_byte,
    input  sre_cmd_t         cmd,
    input  logic [CNT_W-1:0] idx,
    input  logic [CNT_W-1:0] rd_idx,
    output sre_sts_t         sts,
    output logic [LEN_W-1:0] rec_len,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [63:0]      cfg_wdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);

    // Configuration registers.
    logic [1:0]  address_width_reg, address_width_next;
    logic [31:0] start_address_reg, start_address_next;
    logic [63:0] header_text_reg, header_text_next;
    logic [3:0]  header_length_reg, header_length_next;

    // Encoder state.
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [31:0]       next_address_reg, next_address_next;
    logic [31:0]       record_address_reg, record_address_next;
    logic [15:0]       record_total_reg, record_total_next;
    logic              any_record_reg, any_record_next;
    logic              out_valid_reg, out_valid_next;

    // Record being sent.
    logic [3:0]       rec_type_reg, rec_type_next;
    logic [31:0]      rec_addr_reg, rec_addr_next;
    logic [2:0]       rec_abytes_reg, rec_abytes_next;
    logic [LEN_W-1:0] rec_len_reg, rec_len_next;
    logic [7:0]       rec_count_reg, rec_count_next;
    logic             rec_hdr_reg, rec_hdr_next;
    logic [7:0]       sum_reg, sum_next;
    logic [6:0]       out_char_reg, out_char_next;
    logic             out_last_reg;
    logic [7:0]       rd_byte_reg;

    logic [7:0] buffer_mem [MAX_DATA_BYTES];

    logic [1:0]  width_sel;
    logic [31:0] load_addr;
    logic [7:0]  payload_byte;
    logic [7:0]  cur_byte;

    assign width_sel = (address_width_reg == 2'd3) ? 2'd2 : address_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_width_reg  <= '0;
            start_address_reg  <= '0;
            header_text_reg    <= '0;
            header_length_reg  <= '0;
            fill_reg           <= '0;
            next_address_reg   <= '0;
            record_address_reg <= '0;
            record_total_reg   <= '0;
            any_record_reg     <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            address_width_reg  <= address_width_next;
            start_address_reg  <= start_address_next;
            header_text_reg    <= header_text_next;
            header_length_reg  <= header_length_next;
            fill_reg           <= fill_next;
            next_address_reg   <= next_address_next;
            record_address_reg <= record_address_next;
            record_total_reg   <= record_total_next;
            any_record_reg     <= any_record_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            buffer_mem[fill_reg[IDX_W-1:0]] <= data_byte;
        end
        rd_byte_reg    <= buffer_mem[rd_idx[IDX_W-1:0]];
        rec_type_reg   <= rec_type_next;
        rec_addr_reg   <= rec_addr_next;
        rec_abytes_reg <= rec_abytes_next;
        rec_len_reg    <= rec_len_next;
        rec_count_reg  <= rec_count_next;
        rec_hdr_reg    <= rec_hdr_next;
        sum_reg        <= sum_next;
        if (cmd.emit)
        begin
            out_char_reg <= out_char_next;
            out_last_reg <= cmd.last;
        end
    end

    assign payload_byte = rec_hdr_reg ? header_text_reg[{idx[2:0], 3'b000} +: 8]
                                      : rd_byte_reg;

    always_comb
    begin
        unique case (cmd.phase)
            ST_COUNT: cur_byte = rec_count_reg;
            ST_ADDR:  cur_byte = rec_addr_reg[31:24];
            ST_DATA:  cur_byte = payload_byte;
            ST_CSUM:  cur_byte = ~sum_reg;
            default:  cur_byte = rec_count_reg;
        endcase
    end

    always_comb
    begin
        unique case (cmd.phase)
            ST_S:    out_char_next = ASCII_S;
            ST_TYPE: out_char_next = ASCII_ZERO + {3'b000, rec_type_reg};
            ST_NL:   out_char_next = ASCII_NL;
            default: out_char_next = hex_char(cmd.nib ? cur_byte[3:0] : cur_byte[7:4]);
        endcase
    end

    always_comb
    begin
        address_width_next  = address_width_reg;
        start_address_next  = start_address_reg;
        header_text_next    = header_text_reg;
        header_length_next  = header_length_reg;
        fill_next           = fill_reg;
        next_address_next   = next_address_reg;
        record_address_next = record_address_reg;
        record_total_next   = record_total_reg;
        any_record_next     = any_record_reg;
        rec_type_next       = rec_type_reg;
        rec_addr_next       = rec_addr_reg;
        rec_abytes_next     = rec_abytes_reg;
        rec_len_next        = rec_len_reg;
        rec_count_next      = rec_count_reg;
        rec_hdr_next        = rec_hdr_reg;
        sum_next            = sum_reg;
        load_addr           = '0;

        if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_ADDR_WIDTH:    address_width_next = cfg_wdata[1:0];
                CFG_START_ADDRESS:
                begin
                    start_address_next  = cfg_wdata[31:0];
                    next_address_next   = cfg_wdata[31:0];
                    record_address_next = cfg_wdata[31:0];
                end
                CFG_HEADER_TEXT:   header_text_next = cfg_wdata;
                CFG_HEADER_LENGTH: header_length_next = cfg_wdata[3:0];
            endcase
        end

        if (cmd.store)
        begin
            fill_next         = fill_reg + FILL_W'(1);
            next_address_next = next_address_reg + 32'd1;
        end

        if (cmd.load)
        begin
            rec_hdr_next = 1'b0;
            rec_len_next = '0;
            unique case (cmd.kind)
                REC_HEADER:
                begin
                    rec_type_next   = TYPE_HEADER;
                    rec_abytes_next = 3'd2;
                    rec_hdr_next    = 1'b1;
                    rec_len_next    = (header_length_reg > 4'd8) ? LEN_W'(8)
                                                                : LEN_W'(header_length_reg);
                end
                REC_DATA:
                begin
                    rec_type_next   = TYPE_DATA + {2'b00, width_sel};
                    rec_abytes_next = 3'd2 + {1'b0, width_sel};
                    load_addr       = record_address_reg;
                    rec_len_next    = cmd.store ? LEN_W'(fill_reg) + LEN_W'(1)
                                                : LEN_W'(fill_reg);
                    fill_next           = '0;
                    record_address_next = next_address_next;
                    record_total_next   = record_total_reg + 16'd1;
                    any_record_next     = 1'b1;
                end
                REC_COUNT:
                begin
                    rec_type_next   = TYPE_COUNT;
                    rec_abytes_next = 3'd2;
                    load_addr       = {16'h0000, record_total_reg};
                end
                REC_TERM:
                begin
                    // With no data record since reset or the last close, S9 at address 0.
                    if (any_record_reg)
                    begin
                        rec_type_next   = TYPE_TERM - {2'b00, width_sel};
                        rec_abytes_next = 3'd2 + {1'b0, width_sel};
                        load_addr       = start_address_reg;
                    end
                    else
                    begin
                        rec_type_next   = TYPE_TERM;
                        rec_abytes_next = 3'd2;
                    end
                    fill_next           = '0;
                    record_total_next   = '0;
                    any_record_next     = 1'b0;
                    next_address_next   = start_address_reg;
                    record_address_next = start_address_reg;
                end
            endcase
            // The address is left-aligned so that its first byte sits in the top bits.
            unique case (rec_abytes_next)
                3'd2:    rec_addr_next = {load_addr[15:0], 16'h0000};
                3'd3:    rec_addr_next = {load_addr[23:0], 8'h00};
                default: rec_addr_next = load_addr;
            endcase
            rec_count_next = 8'(rec_abytes_next) + 8'(rec_len_next) + 8'd1;
            sum_next       = rec_count_next;
        end
        else if (cmd.emit)
        begin
            if (!cmd.nib && (cmd.phase == ST_ADDR || cmd.phase == ST_DATA))
            begin
                sum_next = sum_reg + cur_byte;
            end
            if (cmd.nib && cmd.phase == ST_ADDR)
            begin
                rec_addr_next = {rec_addr_reg[23:0], 8'h00};
            end
        end
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign sts.out_free  = !out_valid_reg || m_tready;
    assign sts.fill_zero = (fill_reg == '0);
    assign sts.fill_last = (fill_reg == FILL_W'(MAX_DATA_BYTES - 1));
    assign sts.abytes    = rec_abytes_reg;
    assign rec_len       = rec_len_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_char_reg};
    assign m_tlast  = out_last_reg;

    `SRE_NEVER(a_fill_bound, clk, rst_n, fill_reg > FILL_W'(MAX_DATA_BYTES - 1), "fill overrun")
    `SRE_ASSERT(a_sum_seed, clk, rst_n, cmd.load |=> sum_reg == rec_count_reg, "checksum not seeded")
    `SRE_ASSERT(a_data_nonempty, clk, rst_n, (cmd.load && cmd.kind == REC_DATA) |-> (cmd.store || fill_reg != '0), "empty data record")

endmodule

// ----- src/s_record_stream_encoder_top.sv -----
// S-record text encoder.
// Input requests on the s_ channel carry an opcode and a memory byte: header,
// data byte, flush of a partial record, or close (S5 count plus terminator).
// Each output request on the m_ channel is one ASCII character; m_tlast marks
// the final character caused by an input request. Requests causing no text
// (a buffered data byte, a flush with nothing buffered) produce no output.
// A record of A address bytes and N data bytes is 7 + 2 * (A + N) characters,
// sent at one character per cycle unless m_tready stalls, through a single
// output register; m_tvalid rises once the S character of an accepted request
// is registered. A data byte that does not fill the buffer is taken without
// leaving idle. A full 32-bit record of sixteen bytes is 47 characters. Input
// is taken only while no record is being sent; a stall on m_tready holds the
// current character and pauses the sequencer. Reset clears the configuration,
// the buffer fill, the record count and both address counters. The user makes
// configuration writes while the block is idle; the block does not enforce it.
module s_record_stream_encoder_top
    import sre_pkg::*;
#(
    parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF,
    localparam int SPAN  = (MAX_DATA_BYTES > 8) ? MAX_DATA_BYTES : 8,
    localparam int CNT_W = $clog2(SPAN),
    localparam int LEN_W = $clog2(SPAN + 1)
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // opcode[1:0], data_byte[9:2], zero[15:10]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // character[6:0], zero[7]
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);

    sre_cmd_t         cmd;
    sre_sts_t         sts;
    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] rd_idx;
    logic [LEN_W-1:0] rec_len;

    sre_controller #(
        .MAX_DATA_BYTES(MAX_DATA_BYTES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (op_t'(s_tdata[1:0])),
        .sts      (sts),
        .rec_len  (rec_len),
        .cmd      (cmd),
        .idx      (idx),
        .rd_idx   (rd_idx)
    );

    sre_datapath #(
        .MAX_DATA_BYTES(MAX_DATA_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (s_tdata[9:2]),
        .cmd       (cmd),
        .idx       (idx),
        .rd_idx    (rd_idx),
        .sts       (sts),
        .rec_len   (rec_len),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
    import sre_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES = 20;
    localparam int BUFFER_BYTES = 16;

    localparam logic [6:0] CH_S    = 7'h53;
    localparam logic [6:0] CH_ZERO = 7'h30;
    localparam logic [6:0] CH_NL   = 7'h0A;

    localparam logic [3:0] DIGIT_HEADER = 4'd0;
    localparam logic [3:0] DIGIT_DATA   = 4'd1;
    localparam logic [3:0] DIGIT_COUNT  = 4'd5;
    localparam logic [3:0] DIGIT_TERM   = 4'd9;

    typedef struct packed
    {
        logic [6:0] character;
        logic       last_char;
    } text_char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;      // opcode[1:0], data_byte[9:2], zero[15:10]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // character[6:0], zero[7]
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_wdata = '0;

    s_record_stream_encoder_top u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    // Encoder model state and its copy of the registers.
    logic [1:0]  cfg_width;
    logic [31:0] cfg_start;
    logic [63:0] cfg_name;
    logic [3:0]  cfg_name_len;
    logic [7:0]  held_bytes [BUFFER_BYTES];
    int          held_count;
    logic [31:0] byte_address;
    logic [31:0] line_address;
    logic [15:0] line_total;
    bit          data_seen;

    logic [6:0]  item_text [$];
    text_char_t  expected_text [$];

    int errors = 0;
    int requests_sent = 0;
    int chars_checked = 0;
    int records_seen = 0;
    int settings_used = 0;
    int cycle_count = 0;

    bit hold_request = 1'b0;
    bit no_idle = 1'b0;
    int hold_left = 0;

    function automatic logic [6:0] hex_ascii(input logic [3:0] n);
        return (n < 4'd10) ? (CH_ZERO + 7'(n)) : (7'h37 + 7'(n));
    endfunction

    function automatic void put_hex_byte(input logic [7:0] b);
        item_text.push_back(hex_ascii(b[7:4]));
        item_text.push_back(hex_ascii(b[3:0]));
    endfunction

    function automatic void put_record_text(input logic [3:0] digit, input logic [31:0] addr,
                                            input int addr_len,
                                            input logic [7:0] payload [BUFFER_BYTES],
                                            input int n_bytes);
        logic [7:0] count;
        logic [7:0] sum;
        logic [7:0] b;
        count = 8'(addr_len + n_bytes + 1);
        sum = count;
        item_text.push_back(CH_S);
        item_text.push_back(CH_ZERO + 7'(digit));
        put_hex_byte(count);
        for (int i = addr_len - 1; i >= 0; i--)
        begin
            b = addr[8 * i +: 8];
            sum += b;
            put_hex_byte(b);
        end
        for (int i = 0; i < n_bytes; i++)
        begin
            sum += payload[i];
            put_hex_byte(payload[i]);
        end
        put_hex_byte(~sum);
        item_text.push_back(CH_NL);
    endfunction

    function automatic int width_code();
        return (cfg_width == 2'd3) ? 2 : int'(cfg_width);
    endfunction

    function automatic void emit_data_record();
        put_record_text(DIGIT_DATA + 4'(width_code()), line_address, 2 + width_code(),
                        held_bytes, held_count);
        held_count = 0;
        line_address = byte_address;
        line_total = line_total + 16'd1;
        data_seen = 1'b1;
    endfunction

    // Works out the text that one accepted request causes and queues it.
    function automatic void predict_request(input op_t op, input logic [7:0] value);
        logic [7:0] name_bytes [BUFFER_BYTES];
        int         name_count;
        int         w;
        for (int i = 0; i < BUFFER_BYTES; i++)
        begin
            name_bytes[i] = (i < 8) ? cfg_name[8 * i +: 8] : 8'h00;
        end
        item_text.delete();
        unique case (op)
            OP_HEADER:
            begin
                name_count = (cfg_name_len > 4'd8) ? 8 : int'(cfg_name_len);
                put_record_text(DIGIT_HEADER, 32'd0, 2, name_bytes, name_count);
            end
            OP_DATA:
            begin
                held_bytes[held_count] = value;
                held_count++;
                byte_address = byte_address + 32'd1;
                if (held_count >= BUFFER_BYTES)
                begin
                    emit_data_record();
                end
            end
            OP_FLUSH:
            begin
                if (held_count > 0)
                begin
                    emit_data_record();
                end
            end
            default:
            begin
                w = width_code();
                put_record_text(DIGIT_COUNT, {16'd0, line_total}, 2, held_bytes, 0);
                // Without any data record the terminator is always the short form at zero.
                if (data_seen)
                begin
                    put_record_text(DIGIT_TERM - 4'(w), cfg_start, 2 + w, held_bytes, 0);
                end
                else
                begin
                    put_record_text(DIGIT_TERM, 32'd0, 2, held_bytes, 0);
                end
                held_count = 0;
                line_total = '0;
                data_seen = 1'b0;
                byte_address = cfg_start;
                line_address = cfg_start;
            end
        endcase
        foreach (item_text[i])
        begin
            expected_text.push_back('{item_text[i], i == item_text.size() - 1});
        end
    endfunction

    // Receiver: random idling, a steady stretch, and a long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= no_idle || ($urandom_range(99) >= 14);
        end
    end

    always @(posedge clk)
    begin : check_output
        text_char_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_text.size() == 0)
            begin
                $error("character: no expectation waiting, actual %h", m_tdata[6:0]);
                errors++;
            end
            else
            begin
                want = expected_text.pop_front();
                chars_checked++;
                if (want.character == CH_NL)
                begin
                    records_seen++;
                end
                if (m_tdata[6:0] !== want.character)
                begin
                    $error("character: expected %h, actual %h", want.character, m_tdata[6:0]);
                    errors++;
                end
                if (m_tlast !== want.last_char)
                begin
                    $error("last_char: expected %b, actual %b", want.last_char, m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_request(input op_t op, input logic [7:0] value);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= {6'b000000, value, op};
        do
            @(posedge clk);
        while (!s_tready);
        predict_request(op, value);
        requests_sent++;
        gap = 0;
        if (!no_idle && $urandom_range(99) < 14)
        begin
            gap = $urandom_range(4, 1);
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering requests until every queued character has come out.
    task automatic wait_for_text();
        s_tvalid <= 1'b0;
        while (expected_text.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input cfg_reg_t idx, input logic [63:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        unique case (idx)
            CFG_ADDR_WIDTH:    cfg_width = value[1:0];
            CFG_START_ADDRESS:
            begin
                cfg_start = value[31:0];
                byte_address = value[31:0];
                line_address = value[31:0];
            end
            CFG_HEADER_TEXT:   cfg_name = value;
            default:           cfg_name_len = value[3:0];
        endcase
        @(posedge clk);
    endtask

    task automatic send_random_request();
        int r;
        r = $urandom_range(99);
        if (r < 6)
        begin
            send_request(OP_HEADER, 8'($urandom));
        end
        else if (r < 80)
        begin
            send_request(OP_DATA, 8'($urandom));
        end
        else if (r < 91)
        begin
            send_request(OP_FLUSH, 8'($urandom));
        end
        else
        begin
            send_request(OP_CLOSE, 8'($urandom));
        end
    endtask

    task automatic test_reset_state();
        send_request(OP_HEADER, 8'h00);
        send_request(OP_FLUSH, 8'hFF);
        send_request(OP_CLOSE, 8'h00);
        settings_used++;
    endtask

    // Width three, a start address that wraps, an all-ones name and an oversized length.
    task automatic test_register_extremes();
        wait_for_text();
        write_register(CFG_ADDR_WIDTH, 64'd3);
        write_register(CFG_START_ADDRESS, 64'hFFFF_FFFF);
        write_register(CFG_HEADER_TEXT, '1);
        write_register(CFG_HEADER_LENGTH, 64'd15);
        settings_used++;
        send_request(OP_HEADER, 8'h00);
        send_request(OP_DATA, 8'h00);
        send_request(OP_DATA, 8'hFF);
        send_request(OP_FLUSH, 8'h00);
        send_request(OP_CLOSE, 8'h00);
    endtask

    // A full buffer at 16-bit width, with a start address wider than the record shows.
    task automatic test_full_record();
        wait_for_text();
        write_register(CFG_ADDR_WIDTH, 64'd0);
        write_register(CFG_START_ADDRESS, 64'h1234_5678);
        settings_used++;
        for (int i = 0; i < BUFFER_BYTES; i++)
        begin
            send_request(OP_DATA, 8'(i * 17));
        end
        send_request(OP_CLOSE, 8'h00);
    endtask

    task automatic test_random_streams();
        int sent;
        int phase;
        int phase_items;
        int pick;
        logic [63:0] v;
        sent = 0;
        phase = 0;
        while (sent < 400)
        begin
            wait_for_text();
            if ($urandom_range(1))
            begin
                pick = $urandom_range(3);
                v = {$urandom, $urandom};
                v[1:0] = (pick == 0) ? 2'd0 : (pick == 1) ? 2'd3 : 2'($urandom_range(3));
                write_register(CFG_ADDR_WIDTH, v);
            end
            if ($urandom_range(2) == 0)
            begin
                pick = $urandom_range(3);
                v = {$urandom, $urandom};
                if (pick == 0)
                begin
                    v[31:0] = 32'd0;
                end
                else if (pick == 1)
                begin
                    v[31:0] = 32'hFFFF_FFFF - 32'($urandom_range(20));
                end
                write_register(CFG_START_ADDRESS, v);
            end
            if ($urandom_range(2) == 0)
            begin
                pick = $urandom_range(3);
                v = (pick == 0) ? '0 : (pick == 1) ? '1 : {$urandom, $urandom};
                write_register(CFG_HEADER_TEXT, v);
            end
            if ($urandom_range(2) == 0)
            begin
                v = {$urandom, $urandom};
                v[3:0] = 4'($urandom_range(15));
                write_register(CFG_HEADER_LENGTH, v);
            end
            settings_used++;
            no_idle = (phase == 3);
            phase_items = $urandom_range(50, 20);
            for (int i = 0; i < phase_items; i++)
            begin
                send_random_request();
            end
            sent += phase_items;
            phase++;
        end
        no_idle = 1'b0;
    endtask

    // The receiver holds off while bytes keep coming, so the block must stall its input.
    task automatic test_output_stall();
        wait_for_text();
        hold_request = 1'b1;
        for (int i = 0; i < 3 * BUFFER_BYTES; i++)
        begin
            send_request(OP_DATA, 8'($urandom));
        end
        send_request(OP_FLUSH, 8'h00);
        wait_for_text();
    endtask

    initial
    begin
        cfg_width = '0;
        cfg_start = '0;
        cfg_name = '0;
        cfg_name_len = '0;
        held_count = 0;
        byte_address = '0;
        line_address = '0;
        line_total = '0;
        data_seen = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_register_extremes();
        test_full_record();
        test_output_stall();
        test_random_streams();

        wait_for_text();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d requests; checked %0d characters in %0d records.",
                 requests_sent, chars_checked, records_seen);
        $display("Covered %0d register settings, all address widths, stalls and closes.",
                 settings_used);
        if (errors == 0 && expected_text.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
